/* hdl/dmpi_pkg.sv */
// Shared types, codes and series constants for the decimal pi engine.
package dmpi_pkg;

  // Operand width of a pass and width of one digit step value
  localparam int XW = 16;
  localparam int VW = 20;

  // Reciprocal of ten, scaled by 2^23, exact for values below 2^20
  localparam logic [VW-1:0] RECIP10 = 20'd838861;
  localparam int RSH = 23;

  // Whole-array pass kinds
  localparam logic [2:0] K_INIT = 3'd0;  // term := 1/n, sum := term
  localparam logic [2:0] K_MULT = 3'd1;  // term *= odd
  localparam logic [2:0] K_DIVO = 3'd2;  // term /= odd
  localparam logic [2:0] K_DIVN = 3'd3;  // term /= n*n
  localparam logic [2:0] K_ACC  = 3'd4;  // sum -/+= term
  localparam logic [2:0] K_PMUL = 3'd5;  // pi (+)= sum * weight

  // Opcodes and result status codes
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_READ    = 1'b1;
  localparam logic [1:0] ST_DIGIT = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]    kind;
    logic [XW-1:0] xval;
    logic          sub;
    logic          pacc;
  } pass_cmd_t;

  typedef struct packed {
    logic done;
    logic nz;
  } pass_stat_t;

  // Arctangent argument denominators
  function automatic logic [XW-1:0] arc_base(input logic [1:0] a);
    logic [XW-1:0] r;
    case (a)
      2'd0:    r = 16'd8;
      2'd1:    r = 16'd57;
      default: r = 16'd239;
    endcase
    return r;
  endfunction

  function automatic logic [XW-1:0] arc_square(input logic [1:0] a);
    logic [XW-1:0] r;
    case (a)
      2'd0:    r = 16'd64;
      2'd1:    r = 16'd3249;
      default: r = 16'd57121;
    endcase
    return r;
  endfunction

  function automatic logic [XW-1:0] arc_weight(input logic [1:0] a);
    logic [XW-1:0] r;
    case (a)
      2'd0:    r = 16'd24;
      2'd1:    r = 16'd8;
      default: r = 16'd4;
    endcase
    return r;
  endfunction

endpackage

/* hdl/dmpi_pass.sv */
// Digit-array pass unit: three digit memories and one digit-per-cycle datapath.
module dmpi_pass import dmpi_pkg::*; #(
  parameter int STORE_LEN = 4099,
  parameter int AW        = 13,
  parameter int LW        = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  pass_cmd_t     cmd,
  input  logic [LW-1:0] len,
  input  logic [AW-1:0] host_addr,
  output pass_stat_t    stat,
  output logic [3:0]    host_digit
);

  localparam logic [1:0] PS_IDLE  = 2'd0;
  localparam logic [1:0] PS_TBL   = 2'd1;
  localparam logic [1:0] PS_RUN   = 2'd2;
  localparam logic [1:0] PS_DRAIN = 2'd3;

  logic [1:0]    state_r;
  logic          vld_r;
  logic          done_r;
  pass_cmd_t     cmd_r;
  logic [VW-1:0] tbl_r [0:9];
  logic [VW-1:0] run_r;
  logic [3:0]    k_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] widx_r;
  logic [LW-1:0] cnt_r;
  logic [XW-1:0] acc_r;
  logic          nz_r;

  logic [3:0] mem_t [0:STORE_LEN-1];
  logic [3:0] mem_s [0:STORE_LEN-1];
  logic [3:0] mem_p [0:STORE_LEN-1];
  logic [3:0] rd_t_r, rd_s_r, rd_p_r;

  logic          desc;
  logic [3:0]    src_div, q_div, m_src, new_digit;
  logic [VW-1:0] v_div, rem_div, v_mul, q10, d_mul;
  logic [2*VW-1:0] prod;
  logic [4:0]    subt, addt;
  logic [XW-1:0] acc_nxt;
  logic          we_t, we_s, we_p;
  logic [AW-1:0] p_raddr;

  // Multiply and accumulate passes walk from the least significant digit
  assign desc = (cmd_r.kind == K_MULT) || (cmd_r.kind == K_ACC) || (cmd_r.kind == K_PMUL);

  // Long division step: quotient digit by compare against the multiple table
  always_comb begin
    src_div = (cmd_r.kind == K_INIT) ? ((widx_r == '0) ? 4'd1 : 4'd0) : rd_t_r;
    v_div   = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + VW'(src_div);
    q_div   = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (v_div >= tbl_r[k]) q_div = 4'(k);
    end
    rem_div = v_div - tbl_r[q_div];
  end

  // Multiply step: table lookup plus carry, split by ten
  always_comb begin
    m_src = (cmd_r.kind == K_PMUL) ? rd_s_r : rd_t_r;
    if (m_src > 4'd9) m_src = 4'd9;
    v_mul = tbl_r[m_src] + VW'(acc_r) +
            (((cmd_r.kind == K_PMUL) && cmd_r.pacc) ? VW'(rd_p_r) : '0);
    prod  = v_mul * RECIP10;
    q10   = VW'(prod[2*VW-1:RSH]);
    d_mul = v_mul - ((q10 << 3) + (q10 << 1));
  end

  // Select the digit and carry for the current pass kind
  always_comb begin
    subt = 5'(rd_t_r) + 5'(acc_r[0]);
    addt = 5'(rd_s_r) + 5'(rd_t_r) + 5'(acc_r[0]);
    new_digit = '0;
    acc_nxt   = '0;
    case (cmd_r.kind)
      K_INIT, K_DIVO, K_DIVN: begin
        new_digit = q_div;
        acc_nxt   = rem_div[XW-1:0];
      end
      K_MULT, K_PMUL: begin
        new_digit = d_mul[3:0];
        acc_nxt   = q10[XW-1:0];
      end
      K_ACC: begin
        if (cmd_r.sub) begin
          if (5'(rd_s_r) < subt) begin
            new_digit = 4'(5'(rd_s_r) + 5'd10 - subt);
            acc_nxt   = XW'(1);
          end else begin
            new_digit = 4'(5'(rd_s_r) - subt);
          end
        end else begin
          if (addt >= 5'd10) begin
            new_digit = 4'(addt - 5'd10);
            acc_nxt   = XW'(1);
          end else begin
            new_digit = addt[3:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign we_t = vld_r && ((cmd_r.kind == K_INIT) || (cmd_r.kind == K_MULT) ||
                          (cmd_r.kind == K_DIVO) || (cmd_r.kind == K_DIVN));
  assign we_s = vld_r && ((cmd_r.kind == K_INIT) || (cmd_r.kind == K_ACC));
  assign we_p = vld_r && (cmd_r.kind == K_PMUL);
  assign p_raddr = (state_r == PS_IDLE) ? host_addr : idx_r;

  // Digit memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (we_t) mem_t[widx_r] <= new_digit;
    if (we_s) mem_s[widx_r] <= new_digit;
    if (we_p) mem_p[widx_r] <= new_digit;
    rd_t_r <= mem_t[idx_r];
    rd_s_r <= mem_s[idx_r];
    rd_p_r <= mem_p[p_raddr];
  end

  // Pass control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_IDLE;
      vld_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      vld_r  <= (state_r == PS_RUN);
      unique case (state_r)
        PS_IDLE:  if (start) state_r <= PS_TBL;
        PS_TBL:   if (k_r == 4'd9) state_r <= PS_RUN;
        PS_RUN:   if (cnt_r == LW'(1)) state_r <= PS_DRAIN;
        PS_DRAIN: begin
          state_r <= PS_IDLE;
          done_r  <= 1'b1;
        end
        default:  state_r <= PS_IDLE;
      endcase
    end
  end

  // Datapath registers: table fill, address walk, carry chain
  always_ff @(posedge clk) begin
    case (state_r)
      PS_IDLE: begin
        if (start) begin
          cmd_r    <= cmd;
          tbl_r[0] <= '0;
          run_r    <= '0;
          k_r      <= 4'd1;
          cnt_r    <= len;
        end
      end
      PS_TBL: begin
        tbl_r[k_r] <= run_r + VW'(cmd_r.xval);
        run_r      <= run_r + VW'(cmd_r.xval);
        k_r        <= k_r + 4'd1;
        idx_r      <= desc ? AW'(cnt_r - LW'(1)) : '0;
        acc_r      <= '0;
        nz_r       <= 1'b0;
      end
      PS_RUN: begin
        idx_r  <= desc ? idx_r - AW'(1) : idx_r + AW'(1);
        cnt_r  <= cnt_r - LW'(1);
        widx_r <= idx_r;
      end
      default: ;
    endcase
    if (vld_r) begin
      acc_r <= acc_nxt;
      if (cmd_r.kind == K_ACC) nz_r <= nz_r | (rd_t_r != 4'd0);
    end
  end

  assign stat.done  = done_r;
  assign stat.nz    = nz_r;
  assign host_digit = rd_p_r;

endmodule

/* hdl/dmpi_seq.sv */
// Series sequencer: orders the whole-array passes of the three arctangent series.
module dmpi_seq import dmpi_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  pass_stat_t stat,
  output logic       pass_start,
  output pass_cmd_t  cmd,
  output logic       done
);

  localparam logic [2:0] SQ_IDLE = 3'd0;
  localparam logic [2:0] SQ_INIT = 3'd1;
  localparam logic [2:0] SQ_MULT = 3'd2;
  localparam logic [2:0] SQ_DIVO = 3'd3;
  localparam logic [2:0] SQ_DIVN = 3'd4;
  localparam logic [2:0] SQ_ACC  = 3'd5;
  localparam logic [2:0] SQ_PMUL = 3'd6;

  logic [2:0]    state_r;
  logic [1:0]    arc_r;
  logic [XW-1:0] odd_r;
  logic          sub_r;
  logic          go_r;
  logic          done_r;
  logic [XW-1:0] odd_nxt;

  assign odd_nxt = odd_r + XW'(2);

  // Advance one pass at a time, looping on the series until the term is zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      arc_r   <= '0;
      odd_r   <= XW'(1);
      sub_r   <= 1'b1;
      go_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      go_r   <= 1'b0;
      done_r <= 1'b0;
      unique case (state_r)
        SQ_IDLE: if (start) begin
          state_r <= SQ_INIT;
          arc_r   <= '0;
          go_r    <= 1'b1;
        end
        SQ_INIT: if (stat.done) begin
          odd_r   <= XW'(1);
          sub_r   <= 1'b1;
          state_r <= SQ_MULT;
          go_r    <= 1'b1;
        end
        SQ_MULT: if (stat.done) begin
          odd_r   <= odd_nxt;
          state_r <= (odd_nxt != '0) ? SQ_DIVO : SQ_DIVN;
          go_r    <= 1'b1;
        end
        SQ_DIVO: if (stat.done) begin
          state_r <= SQ_DIVN;
          go_r    <= 1'b1;
        end
        SQ_DIVN: if (stat.done) begin
          state_r <= SQ_ACC;
          go_r    <= 1'b1;
        end
        SQ_ACC: if (stat.done) begin
          sub_r   <= !sub_r;
          state_r <= stat.nz ? SQ_MULT : SQ_PMUL;
          go_r    <= 1'b1;
        end
        SQ_PMUL: if (stat.done) begin
          if (arc_r == 2'd2) begin
            state_r <= SQ_IDLE;
            done_r  <= 1'b1;
          end else begin
            arc_r   <= arc_r + 2'd1;
            state_r <= SQ_INIT;
            go_r    <= 1'b1;
          end
        end
        default: state_r <= SQ_IDLE;
      endcase
    end
  end

  // Pass command for the current step
  always_comb begin
    cmd.sub  = sub_r;
    cmd.pacc = (arc_r != 2'd0);
    cmd.kind = K_ACC;
    cmd.xval = '0;
    case (state_r)
      SQ_INIT: begin cmd.kind = K_INIT; cmd.xval = arc_base(arc_r);   end
      SQ_MULT: begin cmd.kind = K_MULT; cmd.xval = odd_r;             end
      SQ_DIVO: begin cmd.kind = K_DIVO; cmd.xval = odd_r;             end
      SQ_DIVN: begin cmd.kind = K_DIVN; cmd.xval = arc_square(arc_r); end
      SQ_PMUL: begin cmd.kind = K_PMUL; cmd.xval = arc_weight(arc_r); end
      default: ;
    endcase
  end

  assign pass_start = go_r;
  assign done       = done_r;

endmodule

/* hdl/decimal_pi_machin_engine_top.sv */
// Top level: command channel, digit count register and result register.
// Read item: result offered after the TS_READ and TS_LOAD states; an out-of-range read goes straight to TS_OUT.
// Compute item: every whole-array pass walks its len digits (len = count + guard)
// at one digit per cycle; a series term costs four passes and the three series
// need about len/1.8 + len/3.5 + len/4.8 terms. One item is in work at a time.
// Reset sets digit_count to 100; the digit memories are not cleared and hold
// valid data only after a compute.
module decimal_pi_machin_engine_top import dmpi_pkg::*; #(
  parameter int MAX_DIGITS   = 4096,
  parameter int GUARD_DIGITS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [11:0] digit_index
  input  logic [0:0]  in_tuser,     // [0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [3:0] digit
  output logic [1:0]  out_tuser,    // [1:0] status
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data
);

  localparam int STORE_LEN = MAX_DIGITS + GUARD_DIGITS;
  localparam int AW        = $clog2(STORE_LEN);
  localparam int LW        = $clog2(STORE_LEN + 1);

  localparam logic [2:0] TS_IDLE = 3'd0;
  localparam logic [2:0] TS_COMP = 3'd1;
  localparam logic [2:0] TS_READ = 3'd2;
  localparam logic [2:0] TS_LOAD = 3'd3;
  localparam logic [2:0] TS_OUT  = 3'd4;

  logic [2:0]    state_r;
  logic [12:0]   cfg_r;
  logic [LW-1:0] len_r;
  logic [AW-1:0] haddr_r;
  logic [3:0]    digit_r;
  logic [1:0]    stat_r;
  logic          seq_go_r;

  logic [31:0]   eff;
  logic [11:0]   idx;
  logic          in_range;
  logic          accept;
  logic          pass_start, seq_done;
  pass_cmd_t     pass_cmd;
  pass_stat_t    pass_stat;
  logic [3:0]    host_digit;

  // Clamp the requested count to the supported range
  always_comb begin
    if (cfg_r == '0) eff = 32'd1;
    else if (32'(cfg_r) > 32'(MAX_DIGITS)) eff = 32'(MAX_DIGITS);
    else eff = 32'(cfg_r);
  end

  assign idx      = in_tdata[11:0];
  assign in_range = 32'(idx) < eff;
  assign accept   = in_tvalid && in_tready;

  assign in_tready  = (state_r == TS_IDLE);
  assign out_tvalid = (state_r == TS_OUT);
  assign out_tdata  = {4'b0, digit_r};
  assign out_tuser  = stat_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= 13'd100;
    else if (cfg_wr_en) cfg_r <= cfg_wr_data;
  end

  // Command handling and result hold
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= TS_IDLE;
      seq_go_r <= 1'b0;
    end else begin
      seq_go_r <= 1'b0;
      unique case (state_r)
        TS_IDLE: if (accept) begin
          if (in_tuser[0] == OP_COMPUTE) begin
            seq_go_r <= 1'b1;
            state_r  <= TS_COMP;
          end else if (in_range) begin
            state_r <= TS_READ;
          end else begin
            state_r <= TS_OUT;
          end
        end
        TS_COMP: if (seq_done) state_r <= TS_OUT;
        TS_READ: state_r <= TS_LOAD;
        TS_LOAD: state_r <= TS_OUT;
        TS_OUT:  if (out_tready) state_r <= TS_IDLE;
        default: state_r <= TS_IDLE;
      endcase
    end
  end

  // Result and operand payload
  always_ff @(posedge clk) begin
    if (state_r == TS_IDLE && accept) begin
      len_r   <= LW'(eff + 32'(GUARD_DIGITS));
      haddr_r <= AW'(idx);
      digit_r <= 4'd0;
      stat_r  <= (in_tuser[0] == OP_COMPUTE) ? ST_DONE : ST_RANGE;
    end else if (state_r == TS_LOAD) begin
      digit_r <= host_digit;
      stat_r  <= ST_DIGIT;
    end
  end

  dmpi_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (seq_go_r),
    .stat       (pass_stat),
    .pass_start (pass_start),
    .cmd        (pass_cmd),
    .done       (seq_done)
  );

  dmpi_pass #(
    .STORE_LEN (STORE_LEN),
    .AW        (AW),
    .LW        (LW)
  ) u_pass (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (pass_start),
    .cmd        (pass_cmd),
    .len        (len_r),
    .host_addr  (haddr_r),
    .stat       (pass_stat),
    .host_digit (host_digit)
  );

  // Checks
  a_no_accept_while_holding: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input ready while result pending");

  a_zero_digit_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_DIGIT) |-> out_tdata[3:0] == 4'd0)
    else $error("nonzero digit with non-digit status");

  a_done_only_computing: assert property (@(posedge clk) disable iff (!rst_n)
    seq_done |-> state_r == TS_COMP) else $error("series done outside compute");

  a_go_enters_compute: assert property (@(posedge clk) disable iff (!rst_n)
    seq_go_r |-> state_r == TS_COMP) else $error("compute start without compute state");

endmodule
